FILE: hdl/ps2mct_pkg.sv
package ps2mct_pkg;

  // Field widths
  localparam int unsigned PosW  = 12;
  localparam int unsigned ByteW = 8;
  // Signed cursor sum: 12-bit position +/- 8-bit delta with sign
  localparam int unsigned SumW  = PosW + 2;

  // Header byte layout
  localparam int unsigned HdrMarkBit  = 3;
  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrRightBit = 1;

  // Reset values
  localparam logic [PosW-1:0] XMaxRst = 12'd639;
  localparam logic [PosW-1:0] YMaxRst = 12'd479;
  localparam logic [PosW-1:0] PosXRst = 12'd320;
  localparam logic [PosW-1:0] PosYRst = 12'd240;

  // Configuration register indexes
  localparam logic RegXMax = 1'b0;
  localparam logic RegYMax = 1'b1;

  // Request codes
  localparam logic ReqByte   = 1'b0;
  localparam logic ReqReport = 1'b1;

  // Packet assembly state
  typedef enum logic [2:0] {
    PKT_HDR = 3'b001,
    PKT_DX  = 3'b010,
    PKT_DY  = 3'b100
  } pkt_state_e;

  // One report word
  typedef struct packed {
    logic [PosW-1:0] cursor_x;
    logic [PosW-1:0] cursor_y;
    logic            left_down;
    logic            right_down;
    logic            left_click;
    logic            right_click;
  } report_t;

endpackage

FILE: hdl/ps2mct_if.sv
// Input channel: mouse bytes and report requests
interface ps2mct_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ps2mct_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// Output channel: cursor reports
interface ps2mct_out_if;
  logic                         valid;
  logic                         ready;
  logic [ps2mct_pkg::PosW-1:0]  cursor_x;
  logic [ps2mct_pkg::PosW-1:0]  cursor_y;
  logic                         left_down;
  logic                         right_down;
  logic                         left_click;
  logic                         right_click;

  modport source (output valid, output cursor_x, output cursor_y, output left_down,
                  output right_down, output left_click, output right_click,
                  input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_down,
                  input right_down, input left_click, input right_click,
                  output ready);
endinterface

FILE: hdl/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet decoder with cursor tracking.
// req_i carries one word per cycle: either a byte from the mouse (req_type 0)
// or a report request (req_type 1). Mouse bytes are assembled into three-byte
// packets (header with bit 3 set, dx, dy); bytes seen while waiting for a
// header without that bit are dropped. Each complete packet moves the cursor
// by +dx / -dy, clamps to [0, x_max] / [0, y_max] and updates the buttons.
// A report request yields one word on rpt_o: position, button levels and
// press edges since the previous report. Mouse bytes yield nothing.
// A report is registered from the state seen in its accept cycle.
// req_i takes one word per cycle while req_i.ready is high; all packet and
// clamp logic sits between the state registers, updated in the accept cycle.
// A two-word output buffer (output register plus skid) lets req_i keep
// accepting while a report waits; req_i.ready drops only when both are full.
// Reset: x_max 639, y_max 479, cursor (320,240), buttons up, no packet begun.
// cfg_* writes x_max (0) or y_max (1); the user keeps it to idle, unenforced.
module ps2_mouse_packet_cursor_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ps2mct_pkg::PosW-1:0]  cfg_wdata_i,
  ps2mct_in_if.sink                    req_i,
  ps2mct_out_if.source                 rpt_o
);

  // Configuration
  logic [ps2mct_pkg::PosW-1:0] x_max_q, y_max_q;

  // Packet and cursor state
  ps2mct_pkg::pkt_state_e       pkt_state_q, pkt_state_d;
  logic [ps2mct_pkg::ByteW-1:0] hdr_q, hdr_d;
  logic [ps2mct_pkg::ByteW-1:0] dx_q, dx_d;
  logic [ps2mct_pkg::PosW-1:0]  pos_x_q, pos_x_d;
  logic [ps2mct_pkg::PosW-1:0]  pos_y_q, pos_y_d;
  logic                         left_q, left_d, right_q, right_d;
  logic                         left_prev_q, left_prev_d, right_prev_q, right_prev_d;

  // Output buffer
  ps2mct_pkg::report_t out_q, skid_q, rpt_d;
  logic                out_valid_q, skid_valid_q;

  logic acc, is_byte, push, pop;
  logic signed [ps2mct_pkg::SumW-1:0] nx, ny;

  assign acc     = req_i.valid && req_i.ready;
  assign is_byte = (req_i.req_type == ps2mct_pkg::ReqByte);
  assign push    = acc && (req_i.req_type == ps2mct_pkg::ReqReport);
  assign pop     = out_valid_q && rpt_o.ready;
  assign req_i.ready = !skid_valid_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_max_q <= ps2mct_pkg::XMaxRst;
      y_max_q <= ps2mct_pkg::YMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ps2mct_pkg::RegXMax: x_max_q <= cfg_wdata_i;
        ps2mct_pkg::RegYMax: y_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Cursor move: signed sums wide enough for 12-bit position +/- 8-bit delta
  assign nx = signed'({2'b00, pos_x_q}) + ps2mct_pkg::SumW'(signed'(dx_q));
  assign ny = signed'({2'b00, pos_y_q}) - ps2mct_pkg::SumW'(signed'(req_i.rx_byte));

  // Packet assembly and report bookkeeping
  always_comb begin
    pkt_state_d  = pkt_state_q;
    hdr_d        = hdr_q;
    dx_d         = dx_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    left_d       = left_q;
    right_d      = right_q;
    left_prev_d  = left_prev_q;
    right_prev_d = right_prev_q;

    rpt_d.cursor_x    = pos_x_q;
    rpt_d.cursor_y    = pos_y_q;
    rpt_d.left_down   = left_q;
    rpt_d.right_down  = right_q;
    rpt_d.left_click  = left_q && !left_prev_q;
    rpt_d.right_click = right_q && !right_prev_q;

    if (acc && is_byte) begin
      unique case (pkt_state_q)
        ps2mct_pkg::PKT_HDR: begin
          if (req_i.rx_byte[ps2mct_pkg::HdrMarkBit]) begin
            hdr_d       = req_i.rx_byte;
            pkt_state_d = ps2mct_pkg::PKT_DX;
          end
        end
        ps2mct_pkg::PKT_DX: begin
          dx_d        = req_i.rx_byte;
          pkt_state_d = ps2mct_pkg::PKT_DY;
        end
        ps2mct_pkg::PKT_DY: begin
          priority if (nx < 0)                                 pos_x_d = '0;
          else if (nx > signed'({2'b00, x_max_q}))             pos_x_d = x_max_q;
          else                                                 pos_x_d = nx[ps2mct_pkg::PosW-1:0];
          priority if (ny < 0)                                 pos_y_d = '0;
          else if (ny > signed'({2'b00, y_max_q}))             pos_y_d = y_max_q;
          else                                                 pos_y_d = ny[ps2mct_pkg::PosW-1:0];
          left_d      = hdr_q[ps2mct_pkg::HdrLeftBit];
          right_d     = hdr_q[ps2mct_pkg::HdrRightBit];
          pkt_state_d = ps2mct_pkg::PKT_HDR;
        end
        default: pkt_state_d = ps2mct_pkg::PKT_HDR;
      endcase
    end else if (push) begin
      left_prev_d  = left_q;
      right_prev_d = right_q;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_state_q  <= ps2mct_pkg::PKT_HDR;
      hdr_q        <= '0;
      dx_q         <= '0;
      pos_x_q      <= ps2mct_pkg::PosXRst;
      pos_y_q      <= ps2mct_pkg::PosYRst;
      left_q       <= 1'b0;
      right_q      <= 1'b0;
      left_prev_q  <= 1'b0;
      right_prev_q <= 1'b0;
    end else begin
      pkt_state_q  <= pkt_state_d;
      hdr_q        <= hdr_d;
      dx_q         <= dx_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      left_q       <= left_d;
      right_q      <= right_d;
      left_prev_q  <= left_prev_d;
      right_prev_q <= right_prev_d;
    end
  end

  // Output register with skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= rpt_d;
      end else begin
        out_q <= rpt_d;
      end
    end else if (push) begin
      skid_q <= rpt_d;
    end
  end

  assign rpt_o.valid       = out_valid_q;
  assign rpt_o.cursor_x    = out_q.cursor_x;
  assign rpt_o.cursor_y    = out_q.cursor_y;
  assign rpt_o.left_down   = out_q.left_down;
  assign rpt_o.right_down  = out_q.right_down;
  assign rpt_o.left_click  = out_q.left_click;
  assign rpt_o.right_click = out_q.right_click;

  // Skid word only ever sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word valid with empty output register");

  // After an accepted report the output register is always valid next cycle
  a_report_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_q)
    else $error("accepted report lost");

  // Nothing is shown without a report having been accepted
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !push) |=> !out_valid_q)
    else $error("report word appeared without request");

  // A byte without the header mark never starts a packet
  a_hdr_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_byte && pkt_state_q == ps2mct_pkg::PKT_HDR &&
     !req_i.rx_byte[ps2mct_pkg::HdrMarkBit]) |=> pkt_state_q == ps2mct_pkg::PKT_HDR)
    else $error("packet started without header mark");

  // The third byte always closes the packet
  a_dy_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_byte && pkt_state_q == ps2mct_pkg::PKT_DY) |=>
      pkt_state_q == ps2mct_pkg::PKT_HDR)
    else $error("packet not closed after dy byte");

endmodule
